// ===== design/kwm_pkg.sv =====
// kwm_pkg: shared constants, register codes and types of the k-way merge block
// used by kwm_cfg, kwm_scan and k_way_merge_linear_scan_unit
package kwm_pkg;

  localparam int DEF_MAX_STREAMS = 32;
  localparam int DEF_WORD_BITS   = 32;

  localparam int LANE_BITS     = 5;
  localparam int DATA_BITS     = 32;
  localparam int COUNT_BITS    = 6;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = 1;

  localparam logic [REG_IDX_BITS-1:0] REG_ASCENDING    = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_STREAM_COUNT = 1'b1;

  localparam logic                  RST_ASCENDING    = 1'b1;
  localparam logic [COUNT_BITS-1:0] RST_STREAM_COUNT = 6'd2;

  typedef struct packed {
    logic                  ascending;
    logic [COUNT_BITS-1:0] stream_count;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic ascending;
  } scan_ctrl_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== design/kwm_cfg.sv =====
// kwm_cfg: apb register file holding the sort direction and the stream count
// depends on kwm_pkg
module kwm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kwm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [kwm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [kwm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output kwm_pkg::cfg_t                     cfg
);

  logic [kwm_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[kwm_pkg::APB_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ascending    <= kwm_pkg::RST_ASCENDING;
      cfg.stream_count <= kwm_pkg::RST_STREAM_COUNT;
    end else if (wr_en) begin
      case (reg_idx)
        kwm_pkg::REG_ASCENDING:    cfg.ascending    <= pwdata[0];
        kwm_pkg::REG_STREAM_COUNT: cfg.stream_count <= pwdata[kwm_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kwm_pkg::REG_ASCENDING:    prdata = kwm_pkg::APB_DATA_BITS'(cfg.ascending);
      kwm_pkg::REG_STREAM_COUNT: prdata = kwm_pkg::APB_DATA_BITS'(cfg.stream_count);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== design/kwm_scan.sv =====
// kwm_scan: stream head memory and the shared compare unit that walks all lanes
// one head per cycle; depends on kwm_pkg
module kwm_scan #(
  parameter int MAX_STREAMS = kwm_pkg::DEF_MAX_STREAMS,
  parameter int HEAD_BITS   = kwm_pkg::DEF_WORD_BITS,
  parameter int LANE_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kwm_pkg::scan_ctrl_t    ctrl,
  input  logic [MAX_STREAMS-1:0] live,
  input  logic                   we,
  input  logic [LANE_W-1:0]      waddr,
  input  logic [HEAD_BITS-1:0]   wdata,
  output kwm_pkg::scan_stat_t    stat,
  output logic [LANE_W-1:0]      best,
  output logic [HEAD_BITS-1:0]   best_word
);

  localparam int CNT_W = $clog2(MAX_STREAMS + 1);

  logic [HEAD_BITS-1:0] mem [MAX_STREAMS];
  logic [HEAD_BITS-1:0] mem_q;
  logic [CNT_W-1:0]     rd_idx;
  logic [LANE_W-1:0]    data_idx;
  logic                 busy;
  logic                 rd_valid;
  logic                 found;
  logic                 issue;
  logic                 take;
  logic [HEAD_BITS-1:0] cmp_a;
  logic [HEAD_BITS-1:0] cmp_b;

  assign issue = busy && (rd_idx != CNT_W'(MAX_STREAMS));

  // one comparator, operands swapped for descending order
  assign cmp_a = ctrl.ascending ? mem_q : best_word;
  assign cmp_b = ctrl.ascending ? best_word : mem_q;
  assign take  = rd_valid && live[data_idx] && (!found || (cmp_a < cmp_b));

  assign stat.done  = busy && !issue && !rd_valid;
  assign stat.found = found;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      mem_q <= mem[rd_idx[LANE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      rd_idx   <= '0;
    end else if (ctrl.start) begin
      busy     <= 1'b1;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      rd_idx   <= '0;
    end else if (busy) begin
      rd_valid <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (stat.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      data_idx <= rd_idx[LANE_W-1:0];
    end
    if (take) begin
      best      <= data_idx;
      best_word <= mem_q;
    end
  end

endmodule

// ===== design/k_way_merge_linear_scan_unit.sv =====
// k_way_merge_linear_scan_unit: top level of the k-way merge, load and merge sequencer
// depends on kwm_pkg, kwm_cfg and kwm_scan
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------
//  item     | item_valid / item_ready         | lane, word, stream_ended
//  result   | result_valid / result_ready     | merged_word, refill_lane, all_done
//  config   | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
//  a word that causes no result leaves the unit idle; one that causes a result goes through
//  accept, one head memory read and compare per lane in the scan unit, then
//  hand-off to the result register
//  reset is synchronous and clears the masks and the phase; the head memory is not cleared
//  item_ready stays low from an accept that starts a scan until the result is in the
//  output register, which holds it while result_ready is low
module k_way_merge_linear_scan_unit #(
  parameter int MAX_STREAMS = kwm_pkg::DEF_MAX_STREAMS,
  parameter int WORD_BITS   = kwm_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kwm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [kwm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [kwm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [kwm_pkg::LANE_BITS-1:0]     lane,
  input  logic [kwm_pkg::DATA_BITS-1:0]     word,
  input  logic                              stream_ended,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [kwm_pkg::DATA_BITS-1:0]     merged_word,
  output logic [kwm_pkg::LANE_BITS-1:0]     refill_lane,
  output logic                              all_done
);

  localparam int LANE_W    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W     = $clog2(MAX_STREAMS + 1);
  localparam int HEAD_BITS = (WORD_BITS < kwm_pkg::DATA_BITS) ? WORD_BITS : kwm_pkg::DATA_BITS;

  kwm_pkg::cfg_t       cfg;
  kwm_pkg::scan_ctrl_t scan_ctrl;
  kwm_pkg::scan_stat_t scan_stat;
  kwm_pkg::state_t     state;

  logic [MAX_STREAMS-1:0] live_mask;
  logic [MAX_STREAMS-1:0] loaded_mask;
  logic [LANE_W-1:0]      waiting_lane;
  logic                   merging;

  logic [LANE_W+kwm_pkg::LANE_BITS:0] lane_wide;
  logic [LANE_W-1:0]                  lane_idx;
  logic                               lane_in_range;
  logic [CNT_W-1:0]                   eff_count;
  logic [MAX_STREAMS-1:0]             count_mask;
  logic [MAX_STREAMS-1:0]             lane_bit;
  logic [MAX_STREAMS-1:0]             loaded_upd;
  logic [MAX_STREAMS-1:0]             live_load;
  logic [MAX_STREAMS-1:0]             live_merge;
  logic                               load_take;
  logic                               load_full;
  logic                               merge_take;
  logic                               accept;
  logic                               head_we;
  logic                               emit_load;

  logic [LANE_W-1:0]                       best;
  logic [HEAD_BITS-1:0]                    best_word;
  logic [LANE_W+kwm_pkg::LANE_BITS:0]      best_wide;
  logic [HEAD_BITS+kwm_pkg::DATA_BITS-1:0] word_wide;

  kwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign lane_wide     = {{(LANE_W + 1){1'b0}}, lane};
  assign lane_idx      = lane_wide[LANE_W-1:0];
  assign lane_in_range = int'(lane) < MAX_STREAMS;

  always_comb begin
    if (cfg.stream_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (int'(cfg.stream_count) > MAX_STREAMS) begin
      eff_count = CNT_W'(MAX_STREAMS);
    end else begin
      eff_count = CNT_W'(cfg.stream_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      count_mask[i] = i < int'(eff_count);
      lane_bit[i]   = lane_in_range && (lane_idx == LANE_W'(i));
    end
  end

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == kwm_pkg::ST_IDLE);

  assign load_take  = !merging && lane_in_range && (int'(lane) < int'(eff_count)) &&
                      !loaded_mask[lane_idx];
  assign loaded_upd = loaded_mask | lane_bit;
  assign load_full  = (loaded_upd & count_mask) == count_mask;
  assign live_load  = live_mask | (stream_ended ? '0 : lane_bit);
  assign merge_take = merging && lane_in_range && (lane_idx == waiting_lane);
  assign live_merge = stream_ended ? (live_mask & ~lane_bit) : live_mask;

  assign head_we = accept && !stream_ended && (load_take || merge_take);

  assign scan_ctrl.start     = accept && ((load_take && load_full) || merge_take);
  assign scan_ctrl.ascending = cfg.ascending;

  kwm_scan #(
    .MAX_STREAMS (MAX_STREAMS),
    .HEAD_BITS   (HEAD_BITS),
    .LANE_W      (LANE_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .live      (live_mask),
    .we        (head_we),
    .waddr     (lane_idx),
    .wdata     (word[HEAD_BITS-1:0]),
    .stat      (scan_stat),
    .best      (best),
    .best_word (best_word)
  );

  assign emit_load = (state == kwm_pkg::ST_EMIT) && (!result_valid || result_ready);
  assign best_wide = {{(kwm_pkg::LANE_BITS + 1){1'b0}}, best};
  assign word_wide = {{kwm_pkg::DATA_BITS{1'b0}}, best_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kwm_pkg::ST_IDLE;
      live_mask    <= '0;
      loaded_mask  <= '0;
      waiting_lane <= '0;
      merging      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        kwm_pkg::ST_IDLE: begin
          if (accept && load_take) begin
            loaded_mask <= loaded_upd;
            if (load_full) begin
              live_mask <= live_load & count_mask;
              state     <= kwm_pkg::ST_SCAN;
            end else begin
              live_mask <= live_load;
            end
          end else if (accept && merge_take) begin
            live_mask <= live_merge;
            state     <= kwm_pkg::ST_SCAN;
          end
        end
        kwm_pkg::ST_SCAN: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              waiting_lane <= best;
              merging      <= 1'b1;
            end else begin
              live_mask    <= '0;
              loaded_mask  <= '0;
              waiting_lane <= '0;
              merging      <= 1'b0;
            end
            state <= kwm_pkg::ST_EMIT;
          end
        end
        kwm_pkg::ST_EMIT: begin
          if (emit_load) begin
            result_valid <= 1'b1;
            state        <= kwm_pkg::ST_IDLE;
          end
        end
        default: state <= kwm_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      merged_word <= scan_stat.found ? word_wide[kwm_pkg::DATA_BITS-1:0] : '0;
      refill_lane <= scan_stat.found ? best_wide[kwm_pkg::LANE_BITS-1:0] : '0;
      all_done    <= !scan_stat.found;
    end
  end

  // scan completes only while the sequencer waits for it
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done |-> (state == kwm_pkg::ST_SCAN))
    else $error("scan done outside scan state");

  // a live lane has always been loaded
  a_live_loaded: assert property (@(posedge clk) disable iff (rst)
    (live_mask & ~loaded_mask) == '0)
    else $error("live lane not loaded");

  // while idle and merging, the pending lane still holds a word
  a_wait_live: assert property (@(posedge clk) disable iff (rst)
    ((state == kwm_pkg::ST_IDLE) && merging) |-> live_mask[waiting_lane])
    else $error("pending lane not live");

  // completion word carries zero payload
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && all_done) |-> ((merged_word == '0) && (refill_lane == '0)))
    else $error("completion word with payload");

endmodule
